// ===== rtl/rr_interval_beat_classifier_top_macros.svh =====
// assertion macros used by the checker file
`ifndef RR_INTERVAL_BEAT_CLASSIFIER_TOP_MACROS_SVH
`define RR_INTERVAL_BEAT_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define RRBC_ASSERT_NOW(lbl, clk, rst_n, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
	else $error(msg);

// next-cycle implication, off while reset is asserted
`define RRBC_ASSERT_NEXT(lbl, clk, rst_n, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
	else $error(msg);

`endif

// ===== rtl/rrbc_pkg.sv =====
package rrbc_pkg;

	// default sizes
	localparam int DEF_WINDOW_DEPTH   = 8;
	localparam int DEF_INTERVAL_BITS  = 12;
	localparam int DEF_AMPLITUDE_BITS = 16;

	// fixed field widths
	localparam int SAMPLE_BITS = 32;
	localparam int COUNT_BITS  = 32;
	localparam int MISS_BITS   = 16;

	// seed interval after reset
	localparam int SEED_RESET = 200;

	// limit percentages
	localparam int LOW_PCT  = 92;
	localparam int HIGH_PCT = 116;
	localparam int MISS_PCT = 166;
	localparam int PCT_BASE = 100;

	// signal level filter: (peak + 7*level) / 8
	localparam int SIGNAL_WEIGHT = 7;
	localparam int SIGNAL_SHIFT  = 3;
	// primary threshold: (3*noise + signal) / 4
	localparam int NOISE_WEIGHT  = 3;
	localparam int PRIMARY_SHIFT = 2;

	typedef enum logic [1:0] {
		ST_FIRST_BEAT = 2'd0,
		ST_BEAT       = 2'd1,
		ST_SEARCHBACK = 2'd2,
		ST_MISS       = 2'd3
	} rrbc_status_t;

endpackage

// ===== rtl/rrbc_ifs.sv =====
// candidate peak request channel
interface rrbc_req_if #(
	parameter int INTERVAL_BITS  = rrbc_pkg::DEF_INTERVAL_BITS,
	parameter int AMPLITUDE_BITS = rrbc_pkg::DEF_AMPLITUDE_BITS
);
	import rrbc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [INTERVAL_BITS-1:0]  rr_interval;
	logic [AMPLITUDE_BITS-1:0] peak_value;
	logic [AMPLITUDE_BITS-1:0] noise_level;
	logic [SAMPLE_BITS-1:0]    sample_index;

	modport source(output valid, rr_interval, peak_value, noise_level, sample_index,
		input ready);
	modport sink(input valid, rr_interval, peak_value, noise_level, sample_index,
		output ready);
endinterface

// classification result channel
interface rrbc_rsp_if #(
	parameter int INTERVAL_BITS  = rrbc_pkg::DEF_INTERVAL_BITS,
	parameter int AMPLITUDE_BITS = rrbc_pkg::DEF_AMPLITUDE_BITS
);
	import rrbc_pkg::*;

	logic                      valid;
	logic                      ready;
	rrbc_status_t              status;
	logic [SAMPLE_BITS-1:0]    peak_time;
	logic [AMPLITUDE_BITS-1:0] beat_value;
	logic [INTERVAL_BITS-1:0]  recent_average;
	logic [INTERVAL_BITS-1:0]  limit_average;
	logic [INTERVAL_BITS-1:0]  low_limit;
	logic [INTERVAL_BITS:0]    high_limit;
	logic [INTERVAL_BITS:0]    miss_limit;
	logic [AMPLITUDE_BITS-1:0] threshold_primary;
	logic [AMPLITUDE_BITS-2:0] threshold_secondary;
	logic [COUNT_BITS-1:0]     beat_count;
	logic [MISS_BITS-1:0]      miss_count;

	modport source(output valid, status, peak_time, beat_value, recent_average,
		limit_average, low_limit, high_limit, miss_limit, threshold_primary,
		threshold_secondary, beat_count, miss_count, input ready);
	modport sink(input valid, status, peak_time, beat_value, recent_average,
		limit_average, low_limit, high_limit, miss_limit, threshold_primary,
		threshold_secondary, beat_count, miss_count, output ready);
endinterface

// ===== rtl/rr_interval_beat_classifier_top.sv =====
// RR-interval beat classifier. Each request carries one candidate R peak and yields exactly
// one result: first beat, accepted beat, searchback request or counted miss, together with
// the averages, limits, thresholds and counters after that peak. A request is registered on
// acceptance and moved into the result register, where it is classified, once that is free;
// one request is taken every cycle, as the window sums, limits and levels are all updated
// with the classification, and the block holds back only while a finished result waits on
// the response side. The seed interval register (reset value 200) is read once, at the
// first peak after reset; write it while idle. No clearing pass is needed after reset.
module rr_interval_beat_classifier_top #(
	parameter int WINDOW_DEPTH   = rrbc_pkg::DEF_WINDOW_DEPTH,
	parameter int INTERVAL_BITS  = rrbc_pkg::DEF_INTERVAL_BITS,
	parameter int AMPLITUDE_BITS = rrbc_pkg::DEF_AMPLITUDE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [INTERVAL_BITS-1:0] cfg_wr_data,
	rrbc_req_if.sink                 req,
	rrbc_rsp_if.source               rsp
);
	import rrbc_pkg::*;

	// request stage
	logic                      v_s1;
	logic [INTERVAL_BITS-1:0]  rr_s1;
	logic [AMPLITUDE_BITS-1:0] peak_s1;
	logic [AMPLITUDE_BITS-1:0] noise_s1;
	logic [SAMPLE_BITS-1:0]    sample_s1;

	logic rsp_v_q;
	logic advance;
	logic take_req;

	// move the registered request into the result register when it is free
	assign advance   = v_s1 && (!rsp_v_q || rsp.ready);
	assign req.ready = !v_s1 || advance;
	assign take_req  = req.valid && req.ready;

	// handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			rsp_v_q <= 1'b0;
		end else begin
			if (take_req) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (take_req) begin
			rr_s1     <= req.rr_interval;
			peak_s1   <= req.peak_value;
			noise_s1  <= req.noise_level;
			sample_s1 <= req.sample_index;
		end
	end

	rrbc_core #(
		.WINDOW_DEPTH   (WINDOW_DEPTH),
		.INTERVAL_BITS  (INTERVAL_BITS),
		.AMPLITUDE_BITS (AMPLITUDE_BITS)
	) u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.fire                (advance),
		.rr_interval         (rr_s1),
		.peak_value          (peak_s1),
		.noise_level         (noise_s1),
		.sample_index        (sample_s1),
		.status              (rsp.status),
		.peak_time           (rsp.peak_time),
		.beat_value          (rsp.beat_value),
		.recent_average      (rsp.recent_average),
		.limit_average       (rsp.limit_average),
		.low_limit           (rsp.low_limit),
		.high_limit          (rsp.high_limit),
		.miss_limit          (rsp.miss_limit),
		.threshold_primary   (rsp.threshold_primary),
		.threshold_secondary (rsp.threshold_secondary),
		.beat_count          (rsp.beat_count),
		.miss_count          (rsp.miss_count)
	);

	assign rsp.valid = rsp_v_q;
endmodule

// ===== rtl/rrbc_scale.sv =====
// floor(value * NUM / DEN) by one constant reciprocal multiply, exact over the input range
module rrbc_scale #(
	parameter int IN_W  = 15,
	parameter int OUT_W = 12,
	parameter int NUM   = 1,
	parameter int DEN   = 8
) (
	input  logic [IN_W-1:0]  value,
	output logic [OUT_W-1:0] result
);
	// 2^SHIFT >= DEN * 2^IN_W keeps the rounding error below one step of the quotient
	localparam int SHIFT = IN_W + $clog2(DEN);
	localparam longint unsigned RECIP =
		((64'(NUM) << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam int RECIP_W = $clog2(RECIP + 64'd1);
	localparam int PROD_W  = IN_W + RECIP_W;

	logic [PROD_W-1:0] product;

	// multiply then drop the fraction
	assign product = PROD_W'(value) * PROD_W'(RECIP);
	assign result  = OUT_W'(product >> SHIFT);
endmodule

// ===== rtl/rrbc_core.sv =====
// beat state, running window sums, limits, levels and the result register
module rrbc_core #(
	parameter int WINDOW_DEPTH   = rrbc_pkg::DEF_WINDOW_DEPTH,
	parameter int INTERVAL_BITS  = rrbc_pkg::DEF_INTERVAL_BITS,
	parameter int AMPLITUDE_BITS = rrbc_pkg::DEF_AMPLITUDE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [INTERVAL_BITS-1:0]         cfg_wr_data,
	input  logic                             fire,
	input  logic [INTERVAL_BITS-1:0]         rr_interval,
	input  logic [AMPLITUDE_BITS-1:0]        peak_value,
	input  logic [AMPLITUDE_BITS-1:0]        noise_level,
	input  logic [rrbc_pkg::SAMPLE_BITS-1:0] sample_index,
	output rrbc_pkg::rrbc_status_t           status,
	output logic [rrbc_pkg::SAMPLE_BITS-1:0] peak_time,
	output logic [AMPLITUDE_BITS-1:0]        beat_value,
	output logic [INTERVAL_BITS-1:0]         recent_average,
	output logic [INTERVAL_BITS-1:0]         limit_average,
	output logic [INTERVAL_BITS-1:0]         low_limit,
	output logic [INTERVAL_BITS:0]           high_limit,
	output logic [INTERVAL_BITS:0]           miss_limit,
	output logic [AMPLITUDE_BITS-1:0]        threshold_primary,
	output logic [AMPLITUDE_BITS-2:0]        threshold_secondary,
	output logic [rrbc_pkg::COUNT_BITS-1:0]  beat_count,
	output logic [rrbc_pkg::MISS_BITS-1:0]   miss_count
);
	import rrbc_pkg::*;

	localparam int POS_W  = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = INTERVAL_BITS + POS_W;
	localparam int LVL_W  = AMPLITUDE_BITS + SIGNAL_SHIFT;
	localparam int PRIM_W = AMPLITUDE_BITS + PRIMARY_SHIFT;

	// state
	logic                      init_q;
	logic [INTERVAL_BITS-1:0]  seed_q;
	logic [INTERVAL_BITS-1:0]  rwin_q [WINDOW_DEPTH];
	logic [INTERVAL_BITS-1:0]  lwin_q [WINDOW_DEPTH];
	logic [SUM_W-1:0]          rsum_q;
	logic [SUM_W-1:0]          lsum_q;
	logic [POS_W-1:0]          pos_q;
	logic [INTERVAL_BITS-1:0]  low_q;
	logic [INTERVAL_BITS:0]    high_q;
	logic [INTERVAL_BITS:0]    miss_q;
	logic [AMPLITUDE_BITS-1:0] sig_q;
	logic [AMPLITUDE_BITS-1:0] prim_q;
	logic [COUNT_BITS-1:0]     total_q;
	logic [MISS_BITS-1:0]      run_q;

	// result payload
	rrbc_status_t              status_q;
	logic [SAMPLE_BITS-1:0]    ptime_q;
	logic [AMPLITUDE_BITS-1:0] bval_q;

	// next-state values
	logic                      in_range;
	logic                      beyond_miss;
	logic                      take_beat;
	logic                      take_miss;
	logic                      accepted;
	rrbc_status_t              status_d;
	logic [SUM_W-1:0]          seed_sum;
	logic [SUM_W-1:0]          rsum_d;
	logic [SUM_W-1:0]          lsum_d;
	logic [INTERVAL_BITS-1:0]  lavg_d;
	logic [LVL_W-1:0]          sig_mix;
	logic [AMPLITUDE_BITS-1:0] sig_d;
	logic [PRIM_W-1:0]         prim_mix;
	logic [AMPLITUDE_BITS-1:0] prim_d;
	logic [INTERVAL_BITS-1:0]  low_d;
	logic [INTERVAL_BITS:0]    high_d;
	logic [INTERVAL_BITS:0]    miss_d;
	logic [POS_W-1:0]          pos_d;

	// interval checks against the current limits
	assign in_range    = (rr_interval > low_q) && ({1'b0, rr_interval} < high_q);
	assign beyond_miss = {1'b0, rr_interval} > miss_q;
	assign take_beat   = init_q && in_range;
	assign take_miss   = init_q && !in_range && !beyond_miss;
	assign accepted    = !init_q || take_beat;

	// classification code
	always_comb begin
		if (!init_q) begin
			status_d = ST_FIRST_BEAT;
		end else if (in_range) begin
			status_d = ST_BEAT;
		end else if (beyond_miss) begin
			status_d = ST_SEARCHBACK;
		end else begin
			status_d = ST_MISS;
		end
	end

	// running sums: on a beat drop the overwritten slot and add the new interval; the limit sum starts as the seed sum
	assign seed_sum = SUM_W'(seed_q) * SUM_W'(WINDOW_DEPTH);
	assign rsum_d = take_beat ? rsum_q - SUM_W'(rwin_q[pos_q]) + SUM_W'(rr_interval) : rsum_q;
	always_comb begin
		if (!init_q) begin
			lsum_d = seed_sum;
		end else if (take_beat) begin
			lsum_d = lsum_q - SUM_W'(lwin_q[pos_q]) + SUM_W'(rr_interval);
		end else begin
			lsum_d = lsum_q;
		end
	end

	assign pos_d = (pos_q == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;

	// signal level and primary threshold
	assign sig_mix  = (LVL_W'(peak_value) + LVL_W'(sig_q) * LVL_W'(SIGNAL_WEIGHT)) >> SIGNAL_SHIFT;
	assign sig_d    = take_beat ? AMPLITUDE_BITS'(sig_mix) : sig_q;
	assign prim_mix = (PRIM_W'(noise_level) * PRIM_W'(NOISE_WEIGHT) + PRIM_W'(sig_d))
		>> PRIMARY_SHIFT;
	assign prim_d   = take_beat ? AMPLITUDE_BITS'(prim_mix) : prim_q;

	// floored limit average of the updated sum, then the percentage limits
	rrbc_scale #(.IN_W(SUM_W), .OUT_W(INTERVAL_BITS), .NUM(1), .DEN(WINDOW_DEPTH))
		u_lavg_d (.value(lsum_d), .result(lavg_d));
	rrbc_scale #(.IN_W(INTERVAL_BITS), .OUT_W(INTERVAL_BITS), .NUM(LOW_PCT), .DEN(PCT_BASE))
		u_low (.value(lavg_d), .result(low_d));
	rrbc_scale #(.IN_W(INTERVAL_BITS), .OUT_W(INTERVAL_BITS + 1), .NUM(HIGH_PCT),
		.DEN(PCT_BASE))
		u_high (.value(lavg_d), .result(high_d));
	rrbc_scale #(.IN_W(INTERVAL_BITS), .OUT_W(INTERVAL_BITS + 1), .NUM(MISS_PCT),
		.DEN(PCT_BASE))
		u_miss (.value(lavg_d), .result(miss_d));

	// window averages shown with the result
	rrbc_scale #(.IN_W(SUM_W), .OUT_W(INTERVAL_BITS), .NUM(1), .DEN(WINDOW_DEPTH))
		u_ravg (.value(rsum_q), .result(recent_average));
	rrbc_scale #(.IN_W(SUM_W), .OUT_W(INTERVAL_BITS), .NUM(1), .DEN(WINDOW_DEPTH))
		u_lavg (.value(lsum_q), .result(limit_average));

	// control state and scalar registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= 1'b0;
			seed_q  <= INTERVAL_BITS'(SEED_RESET);
			rsum_q  <= '0;
			lsum_q  <= '0;
			pos_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			miss_q  <= '0;
			sig_q   <= '0;
			prim_q  <= '0;
			total_q <= '0;
			run_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (fire) begin
				init_q <= 1'b1;
				rsum_q <= rsum_d;
				lsum_q <= lsum_d;
				low_q  <= low_d;
				high_q <= high_d;
				miss_q <= miss_d;
				sig_q  <= sig_d;
				prim_q <= prim_d;
				if (take_beat) begin
					pos_q <= pos_d;
				end
				if (accepted) begin
					total_q <= total_q + 1'b1;
				end
				if (take_beat) begin
					run_q <= '0;
				end else if (take_miss && run_q != '1) begin
					run_q <= run_q + 1'b1;
				end
			end
		end
	end

	// recent window starts empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				rwin_q[i] <= '0;
			end
		end else if (fire && take_beat) begin
			rwin_q[pos_q] <= rr_interval;
		end
	end

	// limit window is filled with the seed at the first beat, before any read
	always_ff @(posedge clk) begin
		if (fire && !init_q) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				lwin_q[i] <= seed_q;
			end
		end else if (fire && take_beat) begin
			lwin_q[pos_q] <= rr_interval;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			ptime_q  <= accepted ? sample_index - 1'b1 : '0;
			bval_q   <= accepted ? peak_value : '0;
		end
	end

	assign status              = status_q;
	assign peak_time           = ptime_q;
	assign beat_value          = bval_q;
	assign low_limit           = low_q;
	assign high_limit          = high_q;
	assign miss_limit          = miss_q;
	assign threshold_primary   = prim_q;
	assign threshold_secondary = prim_q[AMPLITUDE_BITS-1:1];
	assign beat_count          = total_q;
	assign miss_count          = run_q;
endmodule

// ===== rtl/rrbc_checker.sv =====
`include "rr_interval_beat_classifier_top_macros.svh"

// port-level checks of the classifier
module rrbc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input rrbc_pkg::rrbc_status_t           rsp_status,
	input logic [rrbc_pkg::SAMPLE_BITS-1:0] rsp_peak_time,
	input logic [rrbc_pkg::COUNT_BITS-1:0]  rsp_beat_count,
	input logic [rrbc_pkg::MISS_BITS-1:0]   rsp_miss_count
);
	import rrbc_pkg::*;

	logic [1:0] pend_q;
	logic       first_seen_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// requests in flight and first-beat tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			first_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
			if (rsp_acc && rsp_status == ST_FIRST_BEAT) begin
				first_seen_q <= 1'b1;
			end
		end
	end

	// a stalled result holds
	`RRBC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_peak_time) && $stable(rsp_beat_count) && $stable(rsp_miss_count), "stalled result changed")

	// the request side stalls only behind a blocked result
	`RRBC_ASSERT_NOW(a_req_stall, clk, arst_n, !req_ready, rsp_valid && !rsp_ready, "request stalled without back-pressure")

	// at most two requests in flight, and no result without a request
	`RRBC_ASSERT_NOW(a_pending, clk, arst_n, 1'b1, (pend_q <= 2'd2) && (!rsp_valid || pend_q != 2'd0), "result count does not match requests")

	// first beat is reported once, as beat number one
	`RRBC_ASSERT_NOW(a_first_once, clk, arst_n, rsp_acc && rsp_status == ST_FIRST_BEAT, !first_seen_q && rsp_beat_count == COUNT_BITS'(1), "repeated or miscounted first beat")
endmodule

bind rr_interval_beat_classifier_top rrbc_checker u_rrbc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_peak_time  (rsp.peak_time),
	.rsp_beat_count (rsp.beat_count),
	.rsp_miss_count (rsp.miss_count)
);
